// ----- sv/qed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qed_pkg
// Shared types and constants of the quadrature encoder decoder.
// ----------------------------------------------------------------------------
package qed_pkg;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_SET_POS = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_CAPTURE = 2'd3;

  localparam logic [1:0] LATCH_AT3   = 2'd0;
  localparam logic [1:0] LATCH_AT0   = 2'd1;
  localparam logic [1:0] LATCH_HALF  = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  localparam logic [1:0] PINS_ZERO = 2'd0;
  localparam logic [1:0] PINS_ALL  = 2'd3;

  localparam logic CFG_LATCH_MODE = 1'b0;
  localparam logic CFG_TICKS      = 1'b1;

  localparam int          CFG_WIDTH     = 16;
  localparam logic [1:0]  LATCH_RESET   = 2'd0;
  localparam logic [15:0] TICKS_RESET   = 16'd20;
  localparam logic [15:0] RPM_NUMERATOR = 16'd60000;
  localparam int          DIV_STEPS     = 16;

  typedef struct packed {
    logic [1:0]         kind;
    logic               line_a;
    logic               line_b;
    logic signed [31:0] new_position;
    logic [31:0]        timestamp_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         direction;
    logic [31:0]        interval_ms;
    logic [15:0]        rpm;
  } out_item_t;

  // Entry passed from the front part to the back part.
  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         direction;
    logic [31:0]        interval_ms;
  } q_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  function automatic logic [1:0] step_of(input logic [3:0] idx);
    logic [1:0] r;
    r = STEP_NONE;
    if (idx inside {4'd2, 4'd4, 4'd11, 4'd13}) r = STEP_UP;
    else if (idx inside {4'd1, 4'd7, 4'd8, 4'd14}) r = STEP_DOWN;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/quadrature_encoder_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_encoder_decoder
// Quadrature encoder decoder: position, direction, interval and RPM per item.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the queue; the back part pops it in
//   its idle state, then passes the multiply state, the 16-step restoring RPM
//   divider and the output state, which holds the result until out_ready.
// The back part takes a new item only after the last result is taken.
// The front queues up to Q_DEPTH items while the back part is busy.
// Synchronous active-low reset clears the config, encoder, queue pointer and
//   control state, not data registers; latch_mode resets to 0, ticks_per_turn to 20.
module quadrature_encoder_decoder #(
  parameter int Q_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qed_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qed_pkg::out_item_t     out_item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [qed_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  logic [1:0]       latch_mode_r;
  logic [15:0]      ticks_r;
  logic             take;
  logic             q_full, q_empty, q_pop;
  qed_pkg::q_item_t entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_mode_r <= qed_pkg::LATCH_RESET;
      ticks_r      <= qed_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qed_pkg::CFG_LATCH_MODE: latch_mode_r <= cfg_wdata[1:0];
        qed_pkg::CFG_TICKS:      ticks_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  qed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .latch_mode (latch_mode_r),
    .take       (take),
    .item       (in_item),
    .entry      (entry)
  );

  qed_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  qed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ticks     (ticks_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- sv/qed_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qed_front
// Accepts items, updates the encoder state and queues position, direction
// and interval for the back part.
// ----------------------------------------------------------------------------
module qed_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       latch_mode,
  input  wire logic             take,
  input  wire qed_pkg::in_item_t item,
  output qed_pkg::q_item_t      entry
);

  logic [1:0]  last_pins_r, last_pins_nxt;
  logic [31:0] fine_r, fine_nxt;
  logic [31:0] detent_r, detent_nxt;
  logic [31:0] reported_r, reported_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] prev_time_r, prev_time_nxt;
  logic [1:0]  pins;
  logic [1:0]  step;
  logic [1:0]  dir;
  logic [31:0] newpos;

  assign pins   = {item.line_b, item.line_a};
  assign step   = qed_pkg::step_of({last_pins_r, pins});
  assign newpos = item.new_position;

  always_comb begin
    last_pins_nxt = last_pins_r;
    fine_nxt      = fine_r;
    detent_nxt    = detent_r;
    reported_nxt  = reported_r;
    last_time_nxt = last_time_r;
    prev_time_nxt = prev_time_r;
    dir           = qed_pkg::DIR_NONE;
    case (item.kind)
      qed_pkg::KIND_SAMPLE: begin
        if (pins != last_pins_r) begin
          if (step == qed_pkg::STEP_UP) fine_nxt = fine_r + 32'd1;
          else if (step == qed_pkg::STEP_DOWN) fine_nxt = fine_r - 32'd1;
          last_pins_nxt = pins;
          if (latch_mode == qed_pkg::LATCH_AT3 && pins == qed_pkg::PINS_ALL)
            detent_nxt = 32'($signed(fine_nxt) >>> 2);
          else if (latch_mode == qed_pkg::LATCH_AT0 && pins == qed_pkg::PINS_ZERO)
            detent_nxt = 32'($signed(fine_nxt) >>> 2);
          else if (latch_mode == qed_pkg::LATCH_HALF &&
                   (pins == qed_pkg::PINS_ZERO || pins == qed_pkg::PINS_ALL))
            detent_nxt = 32'($signed(fine_nxt) >>> 1);
          prev_time_nxt = last_time_r;
          last_time_nxt = item.timestamp_ms;
        end
      end
      qed_pkg::KIND_SET_POS: begin
        if (latch_mode == qed_pkg::LATCH_AT3 || latch_mode == qed_pkg::LATCH_AT0)
          fine_nxt = {newpos[29:0], fine_r[1:0]};
        else if (latch_mode == qed_pkg::LATCH_HALF)
          fine_nxt = {newpos[30:0], fine_r[0]};
        detent_nxt   = newpos;
        reported_nxt = newpos;
      end
      qed_pkg::KIND_CAPTURE: last_pins_nxt = pins;
      default: ;
    endcase
    if ($signed(reported_nxt) > $signed(detent_nxt)) dir = qed_pkg::DIR_CCW;
    else if ($signed(reported_nxt) < $signed(detent_nxt)) dir = qed_pkg::DIR_CW;
    if (item.kind == qed_pkg::KIND_READ) reported_nxt = detent_nxt;
  end

  assign entry.position    = detent_nxt;
  assign entry.direction   = dir;
  assign entry.interval_ms = last_time_nxt - prev_time_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r <= '0;
      fine_r      <= '0;
      detent_r    <= '0;
      reported_r  <= '0;
      last_time_r <= '0;
      prev_time_r <= '0;
    end else if (take) begin
      last_pins_r <= last_pins_nxt;
      fine_r      <= fine_nxt;
      detent_r    <= detent_nxt;
      reported_r  <= reported_nxt;
      last_time_r <= last_time_nxt;
      prev_time_r <= prev_time_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/qed_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qed_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module qed_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire qed_pkg::q_item_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output qed_pkg::q_item_t      head,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  qed_pkg::q_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_COUNT);
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == LAST) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == LAST) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_COUNT) else $error("queue count beyond depth");
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count missed a push");
  a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("queue count missed a pop");

endmodule
`default_nettype wire

// ----- sv/qed_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qed_back
// Computes the RPM of a queued item with a 16-step restoring divider and
// holds the result item until it is taken.
// ----------------------------------------------------------------------------
module qed_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [15:0]      ticks,
  input  wire logic             q_empty,
  input  wire qed_pkg::q_item_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output qed_pkg::out_item_t    out_item
);

  qed_pkg::bk_state_t state_r, state_nxt;
  qed_pkg::q_item_t   work_r;
  logic [15:0] denom_r;
  logic        zero_r;
  logic [15:0] num_r;
  logic [15:0] rem_r;
  logic [3:0]  cnt_r;
  logic        load_work, start_div, div_step;
  logic [15:0] d;
  logic [16:0] rem_shift;
  logic [17:0] diff;
  logic        ge;
  logic [47:0] prod;

  assign prod      = 48'(work_r.interval_ms) * 48'(ticks);
  assign d         = denom_r;
  assign rem_shift = {rem_r, num_r[15]};
  assign diff      = {1'b0, rem_shift} - {2'b00, d};
  assign ge        = ~diff[17];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qed_pkg::BK_IDLE: if (!q_empty) state_nxt = qed_pkg::BK_MUL;
      qed_pkg::BK_MUL:  state_nxt = qed_pkg::BK_DIV;
      qed_pkg::BK_DIV:  if (cnt_r == 4'(qed_pkg::DIV_STEPS - 1)) state_nxt = qed_pkg::BK_OUT;
      qed_pkg::BK_OUT:  if (out_ready) state_nxt = qed_pkg::BK_IDLE;
      default:          state_nxt = qed_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    load_work = 1'b0;
    start_div = 1'b0;
    div_step  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      qed_pkg::BK_IDLE: load_work = !q_empty;
      qed_pkg::BK_MUL:  start_div = 1'b1;
      qed_pkg::BK_DIV:  div_step  = 1'b1;
      qed_pkg::BK_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign q_pop = load_work;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qed_pkg::BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_div) cnt_r <= '0;
      else if (div_step) cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_work) work_r <= q_head;
    if (start_div) begin
      denom_r <= prod[15:0];
      zero_r  <= (prod == '0) || (prod[47:16] != '0);
      num_r   <= qed_pkg::RPM_NUMERATOR;
      rem_r   <= '0;
    end else if (div_step) begin
      num_r <= {num_r[14:0], ge};
      rem_r <= ge ? diff[15:0] : rem_shift[15:0];
    end
  end

  assign out_item.position    = work_r.position;
  assign out_item.direction   = work_r.direction;
  assign out_item.interval_ms = work_r.interval_ms;
  assign out_item.rpm         = zero_r ? 16'd0 : num_r;

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qed_pkg::BK_DIV && cnt_r == 4'(qed_pkg::DIV_STEPS - 1))
    |=> state_r == qed_pkg::BK_OUT) else $error("divider step count off");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qed_pkg::BK_OUT && !zero_r) |-> rem_r < d)
    else $error("divider remainder not reduced");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_item))
    else $error("result changed while waiting");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == qed_pkg::BK_IDLE && !q_empty)
    else $error("pop outside idle");

endmodule
`default_nettype wire

// ----- test/quadrature_encoder_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_decoder_tb
// Self-checking bench for the quadrature decoder. A short directed table
// covers reset state, invalid jumps, capture, set position at both extremes
// and timestamp wrap. Random encoder traffic then runs under every latch mode
// and a range of ticks-per-turn settings. Every result is compared field by
// field with its typed table row or an in-bench model of the decoder. Both
// handshakes idle at random; the receiver once holds off to back up the input.
// ----------------------------------------------------------------------------
module quadrature_encoder_decoder_tb;

  localparam logic [1:0] LATCH_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 55;

  typedef struct packed {
    qed_pkg::in_item_t  item;
    logic               typed;
    qed_pkg::out_item_t exp;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  qed_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  qed_pkg::out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [qed_pkg::CFG_WIDTH-1:0] cfg_wdata;

  // model of the decoder
  logic [1:0]  m_latch;
  logic [15:0] m_ticks;
  logic [1:0]  m_pins;
  logic [31:0] m_fine;
  logic [31:0] m_detent;
  logic [31:0] m_reported;
  logic [31:0] m_last_time;
  logic [31:0] m_prev_time;
  int step_delta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  qed_pkg::out_item_t pending_reports [$];
  vec_row_t           dir_rows [$];
  logic               item_typed;
  qed_pkg::out_item_t typed_exp;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  logic               calm = 1'b0;
  logic               hold_req = 1'b0;

  // random encoder walk
  logic [1:0]  gen_pins = qed_pkg::PINS_ZERO;
  logic        gen_spin = 1'b1;
  logic [31:0] gen_ts = '0;
  logic [1:0]  cw_next [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  logic [1:0]  ccw_next [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  logic [1:0]  ph_mode [8] = '{qed_pkg::LATCH_AT0, qed_pkg::LATCH_HALF, LATCH_NONE,
                               qed_pkg::LATCH_AT3, qed_pkg::LATCH_HALF, qed_pkg::LATCH_AT0,
                               qed_pkg::LATCH_AT3, qed_pkg::LATCH_HALF};
  logic [15:0] ph_ticks [8] = '{16'd1, 16'd65535, 16'd20, 16'd0,
                                16'd1, 16'd383, 16'd65535, 16'd7};

  quadrature_encoder_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic qed_pkg::out_item_t decode_item(input qed_pkg::in_item_t it);
    qed_pkg::out_item_t r;
    logic [1:0]  pins;
    logic [31:0] np;
    logic [31:0] ivl;
    logic [63:0] denom;
    int          d;
    pins = {it.line_b, it.line_a};
    np = it.new_position;
    case (it.kind)
      qed_pkg::KIND_SAMPLE: begin
        if (pins != m_pins) begin
          d = step_delta[{m_pins, pins}];
          if (d > 0) m_fine = m_fine + 32'd1;
          else if (d < 0) m_fine = m_fine - 32'd1;
          m_pins = pins;
          if (m_latch == qed_pkg::LATCH_AT3 && pins == qed_pkg::PINS_ALL) begin
            m_detent = $signed(m_fine) >>> 2;
          end else if (m_latch == qed_pkg::LATCH_AT0 && pins == qed_pkg::PINS_ZERO) begin
            m_detent = $signed(m_fine) >>> 2;
          end else if (m_latch == qed_pkg::LATCH_HALF &&
                       (pins == qed_pkg::PINS_ZERO || pins == qed_pkg::PINS_ALL)) begin
            m_detent = $signed(m_fine) >>> 1;
          end
          m_prev_time = m_last_time;
          m_last_time = it.timestamp_ms;
        end
      end
      qed_pkg::KIND_SET_POS: begin
        if (m_latch == qed_pkg::LATCH_AT3 || m_latch == qed_pkg::LATCH_AT0)
          m_fine = {np[29:0], m_fine[1:0]};
        else if (m_latch == qed_pkg::LATCH_HALF) m_fine = {np[30:0], m_fine[0]};
        m_detent = np;
        m_reported = np;
      end
      qed_pkg::KIND_CAPTURE: m_pins = pins;
      default: ;
    endcase
    if ($signed(m_reported) > $signed(m_detent)) r.direction = qed_pkg::DIR_CCW;
    else if ($signed(m_reported) < $signed(m_detent)) r.direction = qed_pkg::DIR_CW;
    else r.direction = qed_pkg::DIR_NONE;
    if (it.kind == qed_pkg::KIND_READ) m_reported = m_detent;
    ivl = m_last_time - m_prev_time;
    denom = 64'(ivl) * 64'(m_ticks);
    r.position = m_detent;
    r.interval_ms = ivl;
    r.rpm = (denom == 0) ? 16'd0
                         : 16'(((64'(qed_pkg::RPM_NUMERATOR) << 16) / denom) >> 16);
    return r;
  endfunction

  function automatic vec_row_t mk_row(input logic [1:0] kind, input logic a, input logic b,
                                      input logic [31:0] np, input logic [31:0] ts,
                                      input logic typed, input logic [31:0] pos,
                                      input logic [1:0] dir, input logic [31:0] ivl,
                                      input logic [15:0] rpm);
    vec_row_t r;
    r.item = '{kind, a, b, np, ts};
    r.typed = typed;
    r.exp = '{pos, dir, ivl, rpm};
    return r;
  endfunction

  // predictor, config mirror and result check, all on the rising edge
  always @(posedge clk) begin
    qed_pkg::out_item_t e;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          qed_pkg::CFG_LATCH_MODE: m_latch = cfg_wdata[1:0];
          qed_pkg::CFG_TICKS:      m_ticks = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        e = decode_item(in_item);
        pending_reports.push_back(item_typed ? typed_exp : e);
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result with no item pending");
          mismatch_count++;
        end else begin
          e = pending_reports.pop_front();
          if (out_item.position !== e.position) begin
            $error("position: expected %0d, got %0d", e.position, out_item.position);
            mismatch_count++;
          end
          if (out_item.direction !== e.direction) begin
            $error("direction: expected %0d, got %0d", e.direction, out_item.direction);
            mismatch_count++;
          end
          if (out_item.interval_ms !== e.interval_ms) begin
            $error("interval_ms: expected %0d, got %0d", e.interval_ms, out_item.interval_ms);
            mismatch_count++;
          end
          if (out_item.rpm !== e.rpm) begin
            $error("rpm: expected %0d, got %0d", e.rpm, out_item.rpm);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("quadrature_encoder_decoder_tb NOT OK");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int seg;
    out_ready = 1'b0;
    seg = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        seg = 0;
      end else if (calm) begin
        out_ready = 1'b1;
      end else if (seg > 0) begin
        seg--;
      end else if (!out_ready) begin
        out_ready = 1'b1;
        seg = $urandom_range(0, 9);
      end else begin
        out_ready = 1'b0;
        case ($urandom_range(19))
          0:       seg = $urandom_range(29, 59);
          1, 2, 3: seg = $urandom_range(3, 11);
          default: seg = $urandom_range(0, 2);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic offer_item(input qed_pkg::in_item_t it, input logic typed,
                            input qed_pkg::out_item_t ex);
    int gap;
    gap = 0;
    if (!calm) begin
      case ($urandom_range(99)) inside
        [0:54]:  gap = 0;
        [55:84]: gap = $urandom_range(1, 3);
        [85:96]: gap = $urandom_range(4, 15);
        default: gap = $urandom_range(30, 80);
      endcase
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    item_typed = typed;
    typed_exp = ex;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [qed_pkg::CFG_WIDTH-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random(input int count, input int pause_at);
    qed_pkg::in_item_t it;
    logic [1:0] pins;
    int         n;
    int         r;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      case ($urandom_range(99)) inside
        [0:96]:  gen_ts = gen_ts + ($urandom_range(99) < 75 ? $urandom_range(1, 40)
                                                             : $urandom_range(41, 5000));
        default: gen_ts = $urandom();
      endcase
      it.new_position = $urandom();
      pins = 2'($urandom_range(3));
      r = $urandom_range(99);
      if (r < 72) begin
        it.kind = qed_pkg::KIND_SAMPLE;
        case ($urandom_range(99)) inside
          [0:84]: begin
            if ($urandom_range(9) == 0) gen_spin = !gen_spin;
            gen_pins = gen_spin ? cw_next[gen_pins] : ccw_next[gen_pins];
          end
          [85:91]: ;
          default: gen_pins = 2'($urandom_range(3));
        endcase
        pins = gen_pins;
      end else if (r < 80) begin
        it.kind = qed_pkg::KIND_READ;
      end else if (r < 89) begin
        it.kind = qed_pkg::KIND_SET_POS;
        case ($urandom_range(9))
          0: it.new_position = 32'h7FFF_FFFF;
          1: it.new_position = 32'h8000_0000;
          2, 3: it.new_position = $urandom_range(0, 40) - 20;
          default: ;
        endcase
      end else begin
        it.kind = qed_pkg::KIND_CAPTURE;
        gen_pins = pins;
      end
      it.line_a = pins[0];
      it.line_b = pins[1];
      it.timestamp_ms = gen_ts;
      offer_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    item_typed = 1'b0;
    typed_exp = '0;
    cfg_we = 1'b0;
    cfg_index = qed_pkg::CFG_LATCH_MODE;
    cfg_wdata = '0;
    m_latch = qed_pkg::LATCH_RESET;
    m_ticks = qed_pkg::TICKS_RESET;
    m_pins = qed_pkg::PINS_ZERO;
    m_fine = '0;
    m_detent = '0;
    m_reported = '0;
    m_last_time = '0;
    m_prev_time = '0;

    // directed table, run with reset configuration
    dir_rows.push_back(mk_row(qed_pkg::KIND_READ,    0, 0, 0, 0, 1, 0,
                              qed_pkg::DIR_NONE, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 0, 0, 3, 1, 0,
                              qed_pkg::DIR_NONE, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_CAPTURE, 1, 1, 0, 5, 1, 0,
                              qed_pkg::DIR_NONE, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 1, 0, 9, 1, 0,
                              qed_pkg::DIR_NONE, 0, 0));
    // two-bit jump: no count, times still move
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 0, 0, 10, 1, 0,
                              qed_pkg::DIR_NONE, 10, 300));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 1, 0, 20, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 1, 0, 30, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 0, 0, 40, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 0, 0, 50, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 1, 0, 60, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 1, 0, 70, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 0, 0, 80, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 0, 0, 90, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_READ,    1, 0, 32'hDEAD_BEEF, 95,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_READ,    0, 1, 0, 96, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 0, 0, 100, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 1, 0, 110, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 1, 0, 120, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 0, 0, 130, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SET_POS, 1, 1, 32'h7FFF_FFFF, 131, 1,
                              32'h7FFF_FFFF, qed_pkg::DIR_NONE, 10, 300));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 1, 0, 32'hFFFF_FFFF,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 1, 0, 4, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SET_POS, 0, 0, 32'h8000_0000, 6, 1,
                              32'h8000_0000, qed_pkg::DIR_NONE, 5, 600));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  1, 0, 0, 32'h7FFF_FFFF,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(qed_pkg::KIND_SAMPLE,  0, 0, 32'hFFFF_FFFF, 32'h8000_0000,
                              0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);
    gen_pins = qed_pkg::PINS_ZERO;
    gen_ts = 32'h8000_0000;
    send_random(PHASE_ITEMS, -1);

    for (i = 0; i < 8; i++) begin
      drain_results();
      write_reg(qed_pkg::CFG_LATCH_MODE, qed_pkg::CFG_WIDTH'(ph_mode[i]));
      write_reg(qed_pkg::CFG_TICKS, ph_ticks[i]);
      calm = (i == 1 || i == 5);
      if (i == 1) hold_req = 1'b1;
      send_random(PHASE_ITEMS, (i == 3) ? PHASE_ITEMS / 2 : -1);
    end
    calm = 1'b0;

    drain_results();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("quadrature_encoder_decoder_tb OK");
    end else begin
      $display("quadrature_encoder_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/qed_pkg.sv
sv/qed_front.sv
sv/qed_queue.sv
sv/qed_back.sv
sv/quadrature_encoder_decoder.sv
test/quadrature_encoder_decoder_tb.sv
